>>> rtl/core/ggt_pkg.sv
// Package for the generational grant table: table geometry, operation and
// status codes, controller states and the controller/datapath command and status structs.
// No dependencies.
package ggt_pkg;

	// Table geometry
	localparam int SLOTS     = 1024;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int LIVE_COLS = 32;
	localparam int COL_W     = $clog2(LIVE_COLS);
	localparam int ROWS      = SLOTS / LIVE_COLS;
	localparam int ROW_W     = IDX_W - COL_W;
	localparam int GEN_W     = 32;
	localparam int ADDR_W    = 64;

	// Operation codes
	typedef enum logic [1:0] {
		MODE_MINT    = 2'd0,
		MODE_RESOLVE = 2'd1,
		MODE_REVOKE  = 2'd2
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_FIND,
		S_EXEC
	} state_t;

	// Stored region of one slot
	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] length;
		logic              writable;
	} slot_data_t;

	// Controller to datapath
	typedef struct packed {
		logic in_ready;
		logic clear;
		logic capture;
		logic look;
		logic find;
		logic exec;
	} ggt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_valid;
		logic clear_last;
		logic out_free;
	} ggt_stat_t;

endpackage

>>> rtl/core/ggt_req_if.sv
// Request channel of the grant table: valid/ready handshake plus request fields.
// No dependencies.
interface ggt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        handle_is_grant;
	logic [15:0] handle_index;
	logic [31:0] handle_generation;
	logic [63:0] phys_address;
	logic [63:0] region_length;
	logic        write_allowed;

	modport source (
		output valid, mode, handle_is_grant, handle_index, handle_generation,
		       phys_address, region_length, write_allowed,
		input  ready
	);
	modport sink (
		input  valid, mode, handle_is_grant, handle_index, handle_generation,
		       phys_address, region_length, write_allowed,
		output ready
	);
endinterface

>>> rtl/core/ggt_rsp_if.sv
// Response channel of the grant table: valid/ready handshake plus result fields.
// No dependencies.
interface ggt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] grant_index;
	logic [31:0] grant_generation;
	logic [63:0] region_base;
	logic [63:0] region_size;
	logic        region_writable;

	modport source (
		output valid, status, grant_index, grant_generation,
		       region_base, region_size, region_writable,
		input  ready
	);
	modport sink (
		input  valid, status, grant_index, grant_generation,
		       region_base, region_size, region_writable,
		output ready
	);
endinterface

>>> rtl/core/ggt_ctrl.sv
// Controller of the grant table: clearing pass after reset, then a
// capture / look / find / execute sequence per request beat.
// Depends on ggt_pkg.
module ggt_ctrl
	import ggt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ggt_stat_t stat,
	output ggt_cmd_t  cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d  = S_FIND;
			end
			S_FIND: begin
				cmd.find = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				// wait here while the previous result still sits in the output register
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

>>> rtl/core/ggt_datapath.sv
// Datapath of the grant table: request registers, live-bit rows with a
// row-full summary, generation and region memories, and the output register.
// Depends on ggt_pkg, ggt_req_if, ggt_rsp_if.
module ggt_datapath
	import ggt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ggt_cmd_t  cmd,
	output ggt_stat_t stat,
	ggt_req_if.sink   req,
	ggt_rsp_if.source rsp
);

	// Memories
	logic [LIVE_COLS-1:0] live_mem [ROWS];
	logic [GEN_W-1:0]     gen_mem  [SLOTS];
	slot_data_t           data_mem [SLOTS];

	// Summary of full live rows, cleared at reset
	logic [ROWS-1:0] row_full_q;

	// Clearing pass counter
	logic [IDX_W-1:0] clr_cnt_q;

	// Request registers
	logic [1:0]       mode_q;
	logic             is_grant_q;
	logic [15:0]      hidx_q;
	logic [GEN_W-1:0] hgen_q;
	slot_data_t       wdata_q;

	// Lookup registers
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [IDX_W-1:0]     slot_q;
	logic                 full_q;
	logic [LIVE_COLS-1:0] live_rd_q;
	logic [GEN_W-1:0]     gen_rd_q;
	slot_data_t           data_rd_q;

	// Output register
	logic             out_valid_q;
	status_t          out_status_q;
	logic [15:0]      out_index_q;
	logic [GEN_W-1:0] out_gen_q;
	slot_data_t       out_data_q;

	logic [ROW_W-1:0]     free_row;
	logic [ROW_W-1:0]     row_sel;
	logic [COL_W-1:0]     free_col;
	logic [COL_W-1:0]     col_sel;
	logic [IDX_W-1:0]     slot_sel;
	logic                 check_ok;
	logic [GEN_W-1:0]     gen_inc;
	logic [GEN_W-1:0]     gen_new;
	logic [LIVE_COLS-1:0] live_new;
	logic                 gen_we;
	logic                 data_we;
	logic                 live_we;
	logic                 row_set;
	logic                 row_clr;
	status_t          res_status;
	logic [15:0]      res_index;
	logic [GEN_W-1:0] res_gen;
	slot_data_t       res_data;

	// Handshake and status toward the controller
	assign req.ready       = cmd.in_ready;
	assign stat.in_valid   = req.valid;
	assign stat.clear_last = (clr_cnt_q == IDX_W'(SLOTS - 1));
	assign stat.out_free   = !out_valid_q || rsp.ready;

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q           <= req.mode;
			is_grant_q       <= req.handle_is_grant;
			hidx_q           <= req.handle_index;
			hgen_q           <= req.handle_generation;
			wdata_q.base     <= req.phys_address;
			wdata_q.length   <= req.region_length;
			wdata_q.writable <= req.write_allowed;
		end
	end

	// Lowest row that still has a free slot
	always_comb begin
		free_row = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (!row_full_q[i]) free_row = ROW_W'(i);
		end
	end

	assign row_sel = (mode_q == MODE_MINT) ? free_row : hidx_q[IDX_W-1:COL_W];

	// Look: read the live row
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			row_q     <= row_sel;
			full_q    <= &row_full_q;
			live_rd_q <= live_mem[row_sel];
		end
	end

	// Lowest free slot within the row
	always_comb begin
		free_col = '0;
		for (int i = LIVE_COLS - 1; i >= 0; i--) begin
			if (!live_rd_q[i]) free_col = COL_W'(i);
		end
	end

	assign col_sel  = (mode_q == MODE_MINT) ? free_col : hidx_q[COL_W-1:0];
	assign slot_sel = {row_q, col_sel};

	// Find: read generation and region of the slot
	always_ff @(posedge clk) begin
		if (cmd.find) begin
			col_q     <= col_sel;
			slot_q    <= slot_sel;
			gen_rd_q  <= gen_mem[slot_sel];
			data_rd_q <= data_mem[slot_sel];
		end
	end

	// Handle check shared by resolve and revoke
	assign check_ok = is_grant_q && ({1'b0, hidx_q} < 17'(SLOTS)) &&
	                  live_rd_q[col_q] && (gen_rd_q == hgen_q);

	// Generation advance, skipping zero
	assign gen_inc = gen_rd_q + GEN_W'(1);
	assign gen_new = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

	// Execute: result and updates
	always_comb begin
		res_status = STAT_REJECT;
		res_index  = '0;
		res_gen    = '0;
		res_data   = '0;
		live_new   = live_rd_q;
		gen_we     = 1'b0;
		data_we    = 1'b0;
		live_we    = 1'b0;
		row_set    = 1'b0;
		row_clr    = 1'b0;
		case (mode_q)
			MODE_MINT: begin
				if (full_q) begin
					res_status = STAT_FULL;
				end else begin
					res_status      = STAT_OK;
					res_index       = 16'(slot_q);
					res_gen         = gen_new;
					live_new[col_q] = 1'b1;
					gen_we          = 1'b1;
					data_we         = 1'b1;
					live_we         = 1'b1;
					row_set         = &live_new;
				end
			end
			MODE_RESOLVE: begin
				if (check_ok) begin
					res_status = STAT_OK;
					res_data   = data_rd_q;
				end
			end
			MODE_REVOKE: begin
				if (check_ok) begin
					res_status      = STAT_OK;
					live_new[col_q] = 1'b0;
					live_we         = 1'b1;
					row_clr         = 1'b1;
				end
			end
			default: res_status = STAT_REJECT;
		endcase
	end

	// Generation memory: cleared by the pass, written by mint
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			gen_mem[clr_cnt_q] <= '0;
		end else if (cmd.exec && gen_we) begin
			gen_mem[slot_q] <= gen_new;
		end
	end

	// Region memory: written by mint only
	always_ff @(posedge clk) begin
		if (cmd.exec && data_we) begin
			data_mem[slot_q] <= wdata_q;
		end
	end

	// Live rows: all cleared early in the pass, updated by mint and revoke
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (clr_cnt_q[IDX_W-1:ROW_W] == '0) begin
				live_mem[clr_cnt_q[ROW_W-1:0]] <= '0;
			end
		end else if (cmd.exec && live_we) begin
			live_mem[row_q] <= live_new;
		end
	end

	// Row-full summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_full_q <= '0;
		end else if (cmd.exec) begin
			if (row_set) row_full_q[row_q] <= 1'b1;
			else if (row_clr) row_full_q[row_q] <= 1'b0;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status_q <= res_status;
			out_index_q  <= res_index;
			out_gen_q    <= res_gen;
			out_data_q   <= res_data;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = out_status_q;
	assign rsp.grant_index      = out_index_q;
	assign rsp.grant_generation = out_gen_q;
	assign rsp.region_base      = out_data_q.base;
	assign rsp.region_size      = out_data_q.length;
	assign rsp.region_writable  = out_data_q.writable;

endmodule

>>> rtl/core/generational_grant_table_unit.sv
// Generational grant table, top level: a capability table of 1024 grant slots
// handling mint, resolve and revoke requests, one response beat per request beat.
//
// Channels: req (sink) carries one request beat per mint, resolve or revoke;
// rsp (source) returns exactly one response beat per request, in order.
// Steps: an accepted request beat passes accept, live-row read, slot read and
// execute, and its response beat then appears at rsp from the output register.
// Flow: a request is taken only after the previous one has executed; each request
// reads the slot memories, mint and revoke write them back, and the lowest free
// slot is found in two steps: a 32-row full summary, then a 32-bit live row.
// Reset: arst_n clears the row-full summary and starts a clearing pass over
// all 1024 slots that zeroes all generations and live bits; req.ready stays low
// until it ends.
// Stall: the response sits in an output register; the next request is taken
// and processed meanwhile, and its execute step waits until rsp is free.
// Depends on ggt_pkg, ggt_req_if, ggt_rsp_if, ggt_ctrl, ggt_datapath.
module generational_grant_table_unit
	import ggt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ggt_req_if.sink   req,
	ggt_rsp_if.source rsp
);

	ggt_cmd_t  cmd;
	ggt_stat_t stat;

	// Sequencer
	ggt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Table storage and result path
	ggt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
